### sv/rdc_pkg.sv
// rdc_pkg: shared widths, beat types and the digit glyph function of the
// radix digit converter. No dependencies.

package rdc_pkg;

	localparam int VALUE_W     = 63;
	localparam int BASE_W      = 5;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 7;
	localparam int DIV_W       = 64;
	localparam int STEP_BITS   = 8;
	localparam int DIV_STEPS   = DIV_W / STEP_BITS;
	localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [BASE_W-1:0]  BASE_MIN      = BASE_W'(2);
	localparam logic [BASE_W-1:0]  BASE_MAX      = BASE_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN     = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(65);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
	} job_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_t;

	typedef struct packed {
		logic busy;
		logic dividing;
	} back_status_t;

	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] off;
		off = d - DIGIT_TEN;
		if (d < DIGIT_TEN) begin
			digit_glyph = CHAR_ZERO + CHAR_W'(d);
		end else begin
			digit_glyph = CHAR_A + CHAR_W'(off);
		end
	endfunction

endpackage

### sv/rdc_fifo.sv
// rdc_fifo: small register queue with push/full and pop/empty sides.
// No dependencies.

module rdc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

### sv/rdc_front.sv
// rdc_front: base register, radix selection and the job queue feeding the back end.
// Depends on rdc_pkg and rdc_fifo.

module rdc_front
	import rdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BASE_W-1:0]  base_setting,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	output logic               job_valid,
	input  logic               job_pop,
	output job_t               job
);

	logic [BASE_W-1:0] base_q;
	job_t              job_in;
	logic              job_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_W'(RADIX_DEFAULT);
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_setting;
		end
	end

	// out-of-range bases fall back to ten
	always_comb begin
		job_in.value = value;
		if (base_q < BASE_MIN || base_q > BASE_MAX) begin
			job_in.radix = RADIX_DEFAULT;
		end else begin
			job_in.radix = RADIX_W'(base_q);
		end
	end

	rdc_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(2)
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (job_in),
		.pop   (job_pop),
		.empty (job_empty),
		.rdata (job)
	);

	assign job_valid = !job_empty;

endmodule

### sv/rdc_back.sv
// rdc_back: repeated division by the radix, digit memory and most-significant-first emission.
// Depends on rdc_pkg.

module rdc_back
	import rdc_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	output logic         job_pop,
	input  job_t         job,
	output logic         out_push,
	input  logic         out_full,
	output digit_t       out_beat,
	output back_status_t status
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_READ = 4'b0100,
		S_SEND = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [STEP_CNT_W-1:0]   step_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIV_W-1:0]        rest_q;
	logic [DIGIT_W-1:0]      rem_q;
	logic [RADIX_W-1:0]      radix_q;
	logic [DIGIT_W-1:0]      rd_q;
	logic [DIGIT_W-1:0]      digit_mem_q [MAX_DIGITS];

	logic [STEP_BITS-1:0]    chunk;
	logic [STEP_BITS-1:0]    quo;
	logic [RADIX_W-1:0]      trial;
	logic [DIGIT_W-1:0]      rem_next;
	logic [DIV_W-1:0]        rest_next;
	logic [CNT_W-1:0]        cnt_inc;
	logic [CNT_W-1:0]        cnt_dec;
	logic                    digit_done;
	logic                    more_digits;

	// eight restoring steps per cycle, dividend bits leave the top, quotient bits enter below
	always_comb begin
		chunk    = rest_q[DIV_W-1 -: STEP_BITS];
		quo      = '0;
		rem_next = rem_q;
		trial    = '0;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			trial = {rem_next, chunk[i]};
			if (trial >= radix_q) begin
				quo[i] = 1'b1;
				trial  = trial - radix_q;
			end
			rem_next = trial[DIGIT_W-1:0];
		end
		rest_next = {rest_q[DIV_W-STEP_BITS-1:0], quo};
	end

	assign cnt_inc     = cnt_q + CNT_W'(1);
	assign cnt_dec     = cnt_q - CNT_W'(1);
	assign digit_done  = (state_q == S_DIV) && (step_q == STEP_CNT_W'(DIV_STEPS - 1));
	assign more_digits = (rest_next != '0) && (cnt_inc < CNT_W'(MAX_DIGITS));

	assign job_pop  = (state_q == S_IDLE) && job_valid;
	assign out_push = (state_q == S_SEND) && !out_full;

	assign out_beat.digit_char = digit_glyph(rd_q);
	assign out_beat.last_digit = (cnt_q == '0);

	assign status.busy     = (state_q != S_IDLE);
	assign status.dividing = (state_q == S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_CNT_W'(1);
					if (digit_done) begin
						cnt_q <= cnt_inc;
						if (!more_digits) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					cnt_q   <= cnt_dec;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (!out_full) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			rest_q  <= {1'b0, job.value};
			rem_q   <= '0;
			radix_q <= job.radix;
		end else if (state_q == S_DIV) begin
			rest_q <= rest_next;
			rem_q  <= digit_done ? '0 : rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem_q[cnt_q[IDX_W-1:0]] <= rem_next;
		end
		if (state_q == S_READ) begin
			rd_q <= digit_mem_q[cnt_dec[IDX_W-1:0]];
		end
	end

endmodule

### sv/radix_digit_converter.sv
// radix_digit_converter: one value in, its digits out most significant first.
// The first digit leaves only after all digits of the value are divided out.
// One value is converted at a time; the next job is taken after the last digit is sent,
// at a pace set by the 8-bit-per-cycle remainder divider and the digit memory read port.
// Reset: arst_n clears all queues and the sequencer, base register returns to ten.
// Depends on rdc_pkg, rdc_fifo, rdc_front and rdc_back.

module radix_digit_converter
	import rdc_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BASE_W-1:0]  base_setting,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit
);

	logic         job_valid;
	logic         job_pop;
	job_t         job;
	logic         out_push;
	logic         out_full;
	digit_t       out_beat;
	digit_t       out_head;
	back_status_t status;

	rdc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.base_setting(base_setting),
		.push        (push),
		.full        (full),
		.value       (value),
		.job_valid   (job_valid),
		.job_pop     (job_pop),
		.job         (job)
	);

	rdc_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job),
		.out_push (out_push),
		.out_full (out_full),
		.out_beat (out_beat),
		.status   (status)
	);

	rdc_fifo #(
		.WIDTH($bits(digit_t)),
		.DEPTH(2)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.wdata (out_beat),
		.pop   (pop),
		.empty (empty),
		.rdata (out_head)
	);

	assign digit_char = out_head.digit_char;
	assign last_digit = out_head.last_digit;

`ifndef SYNTHESIS
	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("back end took a job from an empty queue");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (status.busy && status.dividing))
		else $error("job taken but division did not start");

	a_push_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (status.busy && !status.dividing && !out_full))
		else $error("digit beat pushed outside emission or into a full queue");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_beat.last_digit) |=> !status.busy)
		else $error("back end still busy after the last digit");
`endif

endmodule
